/* src/mexp_pkg.sv */
// Package for the modular exponentiation block: payload structs, the
// controller/datapath command and status structs, operand select codes.
// No dependencies.
package mexp_pkg;

   localparam int FIELD_WIDTH = 32;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] base;
      logic [FIELD_WIDTH-1:0] exponent;
      logic [FIELD_WIDTH-1:0] modulus;
   } mexp_req_type;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] power;
      logic                   mod_error;
   } mexp_rsp_type;

   typedef enum logic [1:0] {
      SEL_REDUCE = 2'd0,
      SEL_SQUARE = 2'd1,
      SEL_MULT   = 2'd2
   } mexp_sel_type;

   typedef struct packed {
      logic         load;
      logic         mul_start;
      mexp_sel_type mul_sel;
      logic         exp_shift;
      logic         acc_load;
      logic         rb_load;
      logic         finish;
   } mexp_cmd_type;

   typedef struct packed {
      logic e_msb;
      logic cnt_zero;
      logic e_zero;
      logic m_zero;
      logic mul_done;
   } mexp_status_type;

endpackage

/* src/modular_exponentiation.sv */
// Top level of the modular exponentiation block: controller plus datapath.
// Depends on mexp_pkg, mexp_control, mexp_datapath.
//
//  channel   ports                       handshake
//  request   req (base, exponent, mod)   taken when start && !busy
//  result    rsp (power, mod_error)      rsp_valid high one cycle
//
// One item at a time. Each modular multiply is an issue step followed by a run in
// the shared bit-serial multiply-reduce unit. Busy covers the base reduction, the
// leading-one search, a square per exponent bit below the leading one and a multiply
// per one bit among them, and a finish step. Zero modulus or exponent goes straight
// to the finish step. The result strobes in the same cycle that busy drops.
// Synchronous reset clears the controller and the strobe; no output stall.
module modular_exponentiation
   import mexp_pkg::*;
#(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  mexp_req_type req,
   output logic         rsp_valid,
   output mexp_rsp_type rsp
);

   mexp_cmd_type    cmd;
   mexp_status_type status;

   mexp_control u_control (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   mexp_datapath #(.W(OPERAND_WIDTH)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

endmodule

/* src/mexp_mulmod.sv */
// Interleaved multiply-reduce unit: x * y mod m, one bit of y per cycle.
// Depends on nothing but its parameter; x and acc stay below m.
module mexp_mulmod #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] x,
   input  logic [W-1:0] y,
   input  logic [W-1:0] m,
   output logic         done,
   output logic [W-1:0] product
);

   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  x_ff, x_in;
   logic [W-1:0]  y_ff, y_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   logic [W:0] dbl, dbl_red, sum, sum_red;

   always_comb begin
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
      sum     = dbl_red + (y_ff[W-1] ? {1'b0, x_ff} : {(W+1){1'b0}});
      sum_red = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
   end

   always_comb begin
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         x_in    = x;
         y_in    = y;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = sum_red[W-1:0];
         y_in   = y_ff << 1;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      cnt_ff <= cnt_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

/* src/mexp_datapath.sv */
// Datapath: operand registers, exponent shifter, bit counter, result register.
// Depends on mexp_pkg and mexp_mulmod.
module mexp_datapath
   import mexp_pkg::*;
#(
   parameter int W = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  mexp_req_type    req,
   input  mexp_cmd_type    cmd,
   output mexp_status_type status,
   output logic            rsp_valid,
   output mexp_rsp_type    rsp
);

   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  b_ff, m_ff, rb_ff, acc_ff, e_ff;
   logic [CW-1:0] cnt_ff;
   logic          valid_ff;
   mexp_rsp_type  rsp_ff;

   logic [W-1:0] mul_x, mul_y, product;
   logic         mul_done;
   logic [W-1:0] power_val;

   always_comb begin
      unique case (cmd.mul_sel)
         SEL_REDUCE: begin
            mul_x = W'(1);
            mul_y = b_ff;
         end
         SEL_SQUARE: begin
            mul_x = acc_ff;
            mul_y = acc_ff;
         end
         SEL_MULT: begin
            mul_x = acc_ff;
            mul_y = rb_ff;
         end
         default: begin
            mul_x = acc_ff;
            mul_y = acc_ff;
         end
      endcase
   end

   mexp_mulmod #(.W(W)) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .x       (mul_x),
      .y       (mul_y),
      .m       (m_ff),
      .done    (mul_done),
      .product (product)
   );

   always_comb begin
      priority if (m_ff == '0) power_val = '0;
      else if (e_ff == '0 && cnt_ff == CW'(W)) power_val = (m_ff == W'(1)) ? '0 : W'(1);
      else power_val = acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.finish;
      end
      if (cmd.load) begin
         b_ff   <= req.base[W-1:0];
         e_ff   <= req.exponent[W-1:0];
         m_ff   <= req.modulus[W-1:0];
         cnt_ff <= CW'(W);
      end else if (cmd.exp_shift) begin
         e_ff   <= e_ff << 1;
         cnt_ff <= cnt_ff - CW'(1);
      end
      if (cmd.acc_load) acc_ff <= product;
      if (cmd.rb_load) rb_ff <= product;
      if (cmd.finish) begin
         rsp_ff.power     <= FIELD_WIDTH'(power_val);
         rsp_ff.mod_error <= (m_ff == '0);
      end
   end

   assign status.e_msb    = e_ff[W-1];
   assign status.cnt_zero = (cnt_ff == '0);
   assign status.e_zero   = (e_ff == '0);
   assign status.m_zero   = (m_ff == '0);
   assign status.mul_done = mul_done;
   assign rsp_valid       = valid_ff;
   assign rsp             = rsp_ff;

   a_prod_reduced: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> product < m_ff)
      else $error("mulmod product not reduced");
   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(cmd.finish))
      else $error("result strobe without finish");
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.mod_error |-> rsp.power == '0)
      else $error("error result not zero");

endmodule

/* src/mexp_control.sv */
// Controller: sequences reduce, leading-one search, square and multiply steps.
// Depends on mexp_pkg.
module mexp_control
   import mexp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  mexp_status_type status,
   output mexp_cmd_type    cmd,
   output logic            busy
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_CHECK  = 9'b000000010,
      ST_RWAIT  = 9'b000000100,
      ST_NORM   = 9'b000001000,
      ST_NEXT   = 9'b000010000,
      ST_SQWAIT = 9'b000100000,
      ST_ML     = 9'b001000000,
      ST_MLWAIT = 9'b010000000,
      ST_DONE   = 9'b100000000
   } mexp_state_type;

   mexp_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.mul_sel = SEL_SQUARE;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.m_zero || status.e_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = SEL_REDUCE;
               state_in      = ST_RWAIT;
            end
         end
         ST_RWAIT: begin
            if (status.mul_done) begin
               cmd.acc_load = 1'b1;
               cmd.rb_load  = 1'b1;
               state_in     = ST_NORM;
            end
         end
         ST_NORM: begin
            cmd.exp_shift = 1'b1;
            if (status.e_msb) state_in = ST_NEXT;
         end
         ST_NEXT: begin
            if (status.cnt_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = SEL_SQUARE;
               state_in      = ST_SQWAIT;
            end
         end
         ST_SQWAIT: begin
            if (status.mul_done) begin
               cmd.acc_load = 1'b1;
               if (status.e_msb) begin
                  state_in = ST_ML;
               end else begin
                  cmd.exp_shift = 1'b1;
                  state_in      = ST_NEXT;
               end
            end
         end
         ST_ML: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = SEL_MULT;
            state_in      = ST_MLWAIT;
         end
         ST_MLWAIT: begin
            if (status.mul_done) begin
               cmd.acc_load  = 1'b1;
               cmd.exp_shift = 1'b1;
               state_in      = ST_NEXT;
            end
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule
